// ----- src/krt_pkg.sv -----
// Package for the keyed record table: request and status codes, field widths
// and the result record type shared by the sequencer and the top level.
// No dependencies.
`default_nettype none

package krt_pkg;

	// Field widths fixed by the stream format.
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int IDX_W = 6;
	localparam int REQ_W = 2;
	localparam int ST_W = 2;
	localparam int ENTRY_W = KEY_W + VAL_W;
	localparam int IN_TDATA_W = 64;
	localparam int OUT_TDATA_W = 72;

	// Request kinds.
	localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LIST = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd3;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

	// One result record.
	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0]        index;
		logic                    last;
	} res_t;

	// Builds a result record from its fields.
	function automatic res_t make_res(logic [ST_W-1:0] status, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] value, logic [IDX_W-1:0] index, logic last);
		res_t r;
		r.status = status;
		r.key = key;
		r.value = value;
		r.index = index;
		r.last = last;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/krt_ram.sv -----
// Generic simple dual-port RAM: one write port and one read port with a
// registered read output. No dependencies.
`default_nettype none

module krt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Storage array; a read holds its data until the next read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- src/krt_seq.sv -----
// Request sequencer of the keyed record table: decodes requests, walks the
// record memory for list, search and delete, and holds the result register.
// Depends on krt_pkg.
`default_nettype none

module krt_seq #(
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request side
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [krt_pkg::REQ_W-1:0]     in_req,
	input  wire logic [krt_pkg::KEY_W-1:0]     in_key,
	input  wire logic [krt_pkg::VAL_W-1:0]     in_value,
	// result side
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output krt_pkg::res_t                      out_res,
	// fill level of the table
	output logic [CW-1:0]                      count,
	// record memory
	output logic                               wr_en,
	output logic [AW-1:0]                      wr_addr,
	output logic [krt_pkg::ENTRY_W-1:0]        wr_data,
	output logic                               rd_en,
	output logic [AW-1:0]                      rd_addr,
	input  wire logic [krt_pkg::ENTRY_W-1:0]   rd_data
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ONE   = 4'b0010,
		S_SCAN  = 4'b0100,
		S_SHIFT = 4'b1000
	} state_t;

	state_t                        state_q, state_d;
	logic [CW-1:0]                 count_q, count_d;
	logic [AW-1:0]                 ptr_q, ptr_d;
	logic [krt_pkg::REQ_W-1:0]     req_q;
	logic [krt_pkg::KEY_W-1:0]     key_q;
	krt_pkg::res_t                 res_q, res_d;
	logic                          out_valid_q;
	krt_pkg::res_t                 out_res_q;
	logic                          emit;
	krt_pkg::res_t                 emit_res;
	logic                          can_emit;
	logic [CW-1:0]                 ptr_nxt, ptr_nxt2;
	logic                          last_ent, shift_done;
	logic [krt_pkg::KEY_W-1:0]     rd_key;
	logic [krt_pkg::VAL_W-1:0]     rd_val;
	krt_pkg::res_t                 entry_res;

	assign can_emit = !out_valid_q || out_ready;
	assign ptr_nxt = CW'(ptr_q) + CW'(1);
	assign ptr_nxt2 = ptr_nxt + CW'(1);
	assign last_ent = (ptr_nxt == count_q);
	assign shift_done = (ptr_nxt2 == count_q);
	assign rd_key = rd_data[krt_pkg::KEY_W-1:0];
	assign rd_val = rd_data[krt_pkg::ENTRY_W-1:krt_pkg::KEY_W];
	assign entry_res = krt_pkg::make_res(krt_pkg::ST_OK, rd_key, rd_val,
		krt_pkg::IDX_W'(ptr_q), last_ent);

	// Next-state logic: at most one memory read and at most one write per cycle.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		ptr_d = ptr_q;
		res_d = res_q;
		wr_en = 1'b0;
		wr_addr = ptr_q;
		wr_data = rd_data;
		rd_en = 1'b0;
		rd_addr = ptr_q;
		emit = 1'b0;
		emit_res = res_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_req == krt_pkg::REQ_ADD) begin
						if (count_q == CW'(DEPTH)) begin
							res_d = krt_pkg::make_res(krt_pkg::ST_FULL, '0, '0, '0, 1'b1);
						end else begin
							wr_en = 1'b1;
							wr_addr = count_q[AW-1:0];
							wr_data = {in_value, in_key};
							count_d = count_q + CW'(1);
							res_d = krt_pkg::make_res(krt_pkg::ST_OK, in_key, in_value,
								krt_pkg::IDX_W'(count_q), 1'b1);
						end
						state_d = S_ONE;
					end else if (count_q == '0) begin
						res_d = krt_pkg::make_res(krt_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
						state_d = S_ONE;
					end else begin
						rd_en = 1'b1;
						rd_addr = '0;
						ptr_d = '0;
						state_d = S_SCAN;
					end
				end
			end
			S_ONE: begin
				if (can_emit) begin
					emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (req_q == krt_pkg::REQ_LIST) begin
					// One record per transfer; the next read waits for the result slot.
					if (can_emit) begin
						emit = 1'b1;
						emit_res = entry_res;
						if (last_ent) begin
							state_d = S_IDLE;
						end else begin
							rd_en = 1'b1;
							rd_addr = ptr_nxt[AW-1:0];
							ptr_d = ptr_nxt[AW-1:0];
						end
					end
				end else if (rd_key == key_q) begin
					res_d = entry_res;
					res_d.last = 1'b1;
					if (req_q == krt_pkg::REQ_DELETE && !last_ent) begin
						rd_en = 1'b1;
						rd_addr = ptr_nxt[AW-1:0];
						state_d = S_SHIFT;
					end else begin
						if (req_q == krt_pkg::REQ_DELETE) begin
							count_d = count_q - CW'(1);
						end
						state_d = S_ONE;
					end
				end else if (last_ent) begin
					res_d = krt_pkg::make_res(krt_pkg::ST_NOTFOUND, '0, '0, '0, 1'b1);
					state_d = S_ONE;
				end else begin
					rd_en = 1'b1;
					rd_addr = ptr_nxt[AW-1:0];
					ptr_d = ptr_nxt[AW-1:0];
				end
			end
			S_SHIFT: begin
				// The read data holds entry ptr+1; it moves down to ptr.
				wr_en = 1'b1;
				wr_addr = ptr_q;
				wr_data = rd_data;
				if (shift_done) begin
					count_d = count_q - CW'(1);
					state_d = S_ONE;
				end else begin
					rd_en = 1'b1;
					rd_addr = ptr_nxt2[AW-1:0];
					ptr_d = ptr_nxt[AW-1:0];
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request fields, walk pointer and result payload.
	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		res_q <= res_d;
		if (in_valid && in_ready) begin
			req_q <= in_req;
			key_q <= in_key;
		end
		if (emit) begin
			out_res_q <= emit_res;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_res = out_res_q;
	assign count = count_q;

endmodule

`default_nettype wire

// ----- src/keyed_record_table.sv -----
// Keyed record table, top level: stream ports, record memory and sequencer.
// Depends on krt_pkg, krt_ram and krt_seq.
//
// Usage: requests arrive on the s_axis channel (tuser = request kind,
// tdata = key and value); results leave on m_axis (tuser = status,
// tdata = key, value and table position, tlast on the final result of a
// request). One request is worked on at a time; s_axis_tready is high
// only while the sequencer is idle.
// Add, and any request on an empty table, gives a single result. A search
// walks the records from position 0 and stops at the first hit or at the
// end; a delete then moves each later record down one position. A list
// gives one result per cycle while the receiver takes them. The walk over
// the record memory makes at most one read per cycle.
// When the receiver stalls, the result register holds its transfer and a
// list walk pauses; a new request is still taken while the last result waits.
// Reset clears the entry count, the sequencer state and the result valid flag;
// the memory contents are not cleared and no clearing pass is needed.
`default_nettype none

module keyed_record_table #(
	parameter int DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [31:0] rec_key, [63:32] rec_value
	input  wire logic [krt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [1:0] req_type
	input  wire logic [krt_pkg::REQ_W-1:0]         s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [31:0] out_key, [63:32] out_value, [69:64] out_index, [71:70] zero
	output logic [krt_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	// [1:0] status
	output logic [krt_pkg::ST_W-1:0]               m_axis_tuser,
	output logic                                   m_axis_tlast
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PAD_W = krt_pkg::OUT_TDATA_W - krt_pkg::ENTRY_W - krt_pkg::IDX_W;

	logic                          wr_en, rd_en;
	logic [AW-1:0]                 wr_addr, rd_addr;
	logic [krt_pkg::ENTRY_W-1:0]   wr_data, rd_data;
	krt_pkg::res_t                 res;
	logic [CW-1:0]                 count;

	// Record memory: value in the upper half, key in the lower half.
	krt_ram #(
		.WIDTH(krt_pkg::ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Request sequencer and result register.
	krt_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_req(s_axis_tuser),
		.in_key(s_axis_tdata[krt_pkg::KEY_W-1:0]),
		.in_value(s_axis_tdata[krt_pkg::ENTRY_W-1:krt_pkg::KEY_W]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res(res),
		.count(count),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Pack the result record onto the output stream.
	assign m_axis_tdata = {PAD_W'(0), res.index, res.value, res.key};
	assign m_axis_tuser = res.status;
	assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
	// The table never holds more than DEPTH records.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(DEPTH))
		else $error("entry count above capacity");

	// A full report carries no record and closes its request.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == krt_pkg::ST_FULL |->
			m_axis_tlast && m_axis_tdata == '0)
		else $error("full status with record fields set");

	// Requests are worked on one at a time.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_keyed_record_table.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for keyed_record_table: directed and random add, list,
// search and delete requests, with results checked against a table model kept here.
// Depends on krt_pkg and the keyed_record_table RTL.

module tb_keyed_record_table;

	localparam int TBL_DEPTH = 64;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 2 * TBL_DEPTH + 16;
	localparam int PHASE_ITEMS = 45;

	// One row of the directed table; exp_* are used only when typed is set.
	typedef struct packed {
		logic [krt_pkg::REQ_W-1:0] req;
		logic [krt_pkg::KEY_W-1:0] key;
		logic [krt_pkg::VAL_W-1:0] value;
		logic                      typed;
		logic [krt_pkg::ST_W-1:0]  status;
		logic [krt_pkg::KEY_W-1:0] exp_key;
		logic [krt_pkg::VAL_W-1:0] exp_value;
		logic [krt_pkg::IDX_W-1:0] exp_index;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [krt_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic [krt_pkg::REQ_W-1:0]       s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [krt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [krt_pkg::ST_W-1:0]        m_axis_tuser;
	logic                            m_axis_tlast;

	// Table contents as the testbench tracks them.
	logic [krt_pkg::KEY_W-1:0] tbl_key [TBL_DEPTH];
	logic [krt_pkg::VAL_W-1:0] tbl_value [TBL_DEPTH];
	int                        tbl_count;

	// Results still owed by the block, oldest first.
	krt_pkg::res_t pending_results[$];

	int snd_idle_pct;
	int rcv_stall_pct;
	bit hold_request;
	int n_errors;
	int n_checked;
	int n_requests;
	int n_by_req [4];
	int n_full_adds;
	int n_on_empty;
	int n_not_found;
	int n_full_lists;

	always #5 clk = ~clk;

	keyed_record_table #(
		.DEPTH(TBL_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// Applies one request to the tracked table and returns the results it causes.
	function automatic void apply_request(input logic [krt_pkg::REQ_W-1:0] req,
			input logic [krt_pkg::KEY_W-1:0] key, input logic [krt_pkg::VAL_W-1:0] value,
			ref krt_pkg::res_t outs[$]);
		int pos;
		outs = {};
		if (req == krt_pkg::REQ_ADD) begin
			if (tbl_count >= TBL_DEPTH) begin
				outs.push_back(krt_pkg::res_t'{krt_pkg::ST_FULL, '0, '0, '0, 1'b1});
				n_full_adds++;
			end else begin
				tbl_key[tbl_count] = key;
				tbl_value[tbl_count] = value;
				outs.push_back(krt_pkg::res_t'{krt_pkg::ST_OK, key, value,
					krt_pkg::IDX_W'(tbl_count), 1'b1});
				tbl_count++;
			end
			return;
		end
		if (tbl_count == 0) begin
			outs.push_back(krt_pkg::res_t'{krt_pkg::ST_EMPTY, '0, '0, '0, 1'b1});
			n_on_empty++;
			return;
		end
		if (req == krt_pkg::REQ_LIST) begin
			for (int i = 0; i < tbl_count; i++)
				outs.push_back(krt_pkg::res_t'{krt_pkg::ST_OK, tbl_key[i], tbl_value[i],
					krt_pkg::IDX_W'(i), i == tbl_count - 1});
			if (tbl_count == TBL_DEPTH)
				n_full_lists++;
			return;
		end
		// Search and delete both act on the first matching key.
		pos = -1;
		for (int i = 0; i < tbl_count && pos < 0; i++)
			if (tbl_key[i] == key)
				pos = i;
		if (pos < 0) begin
			outs.push_back(krt_pkg::res_t'{krt_pkg::ST_NOTFOUND, '0, '0, '0, 1'b1});
			n_not_found++;
			return;
		end
		outs.push_back(krt_pkg::res_t'{krt_pkg::ST_OK, tbl_key[pos], tbl_value[pos],
			krt_pkg::IDX_W'(pos), 1'b1});
		if (req == krt_pkg::REQ_DELETE) begin
			for (int j = pos; j + 1 < tbl_count; j++) begin
				tbl_key[j] = tbl_key[j + 1];
				tbl_value[j] = tbl_value[j + 1];
			end
			tbl_count--;
		end
	endfunction

	// Picks a stored key with the given chance, else a small key prone to repeats
	// or a fully random one.
	function automatic logic [krt_pkg::KEY_W-1:0] pick_key(input int hit_pct);
		if (tbl_count > 0 && $urandom_range(99) < hit_pct)
			return tbl_key[$urandom_range(tbl_count - 1)];
		if ($urandom_range(1) == 0)
			return krt_pkg::KEY_W'($urandom_range(15)) - krt_pkg::KEY_W'(2);
		return $urandom();
	endfunction

	// Offers one request and waits for its transfer; the expected results are
	// queued at the edge where the transfer happens.
	task automatic send_request(input logic [krt_pkg::REQ_W-1:0] req,
			input logic [krt_pkg::KEY_W-1:0] key, input logic [krt_pkg::VAL_W-1:0] value,
			input bit typed, input krt_pkg::res_t typed_res);
		krt_pkg::res_t outs[$];
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {value, key};
		s_axis_tuser = req;
		do
			@(posedge clk);
		while (!s_axis_tready);
		apply_request(req, key, value, outs);
		if (typed)
			pending_results.push_back(typed_res);
		else
			foreach (outs[i])
				pending_results.push_back(outs[i]);
		n_requests++;
		n_by_req[req]++;
	endtask

	// Random request drawn with the given weights per kind.
	task automatic send_random(input int w_add, input int w_list, input int w_search,
			input int w_delete);
		int r;
		logic [krt_pkg::REQ_W-1:0] req;
		r = $urandom_range(w_add + w_list + w_search + w_delete - 1);
		if (r < w_add)
			req = krt_pkg::REQ_ADD;
		else if (r < w_add + w_list)
			req = krt_pkg::REQ_LIST;
		else if (r < w_add + w_list + w_search)
			req = krt_pkg::REQ_SEARCH;
		else
			req = krt_pkg::REQ_DELETE;
		send_request(req, pick_key(req == krt_pkg::REQ_ADD ? 30 : 80), $urandom(), 1'b0, '0);
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin : result_sink
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				m_axis_tready = ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	// Each result transfer is checked against the oldest expected result.
	always @(posedge clk) begin : result_check
		krt_pkg::res_t want;
		logic signed [krt_pkg::KEY_W-1:0] got_key;
		logic signed [krt_pkg::VAL_W-1:0] got_value;
		logic [krt_pkg::IDX_W-1:0] got_index;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_key = m_axis_tdata[krt_pkg::KEY_W-1:0];
			got_value = m_axis_tdata[krt_pkg::ENTRY_W-1:krt_pkg::KEY_W];
			got_index = m_axis_tdata[krt_pkg::ENTRY_W+krt_pkg::IDX_W-1:krt_pkg::ENTRY_W];
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d key %0d value %0d index %0d",
					m_axis_tuser, got_key, got_value, got_index);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (m_axis_tuser !== want.status) begin
					$error("status mismatch: expected %0d, got %0d", want.status, m_axis_tuser);
					n_errors++;
				end
				if (got_key !== want.key) begin
					$error("out_key mismatch: expected %0d, got %0d", want.key, got_key);
					n_errors++;
				end
				if (got_value !== want.value) begin
					$error("out_value mismatch: expected %0d, got %0d", want.value, got_value);
					n_errors++;
				end
				if (got_index !== want.index) begin
					$error("out_index mismatch: expected %0d, got %0d", want.index, got_index);
					n_errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last mismatch: expected %0d, got %0d", want.last, m_axis_tlast);
					n_errors++;
				end
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$error("no transfer for %0d cycles", IDLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		dir_row_t directed[$];
		int snd_tab [3];
		int rcv_tab [3];
		int mode;
		snd_tab = '{57, 0, 21};
		rcv_tab = '{0, 57, 21};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = krt_pkg::REQ_ADD;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		hold_request = 1'b0;
		tbl_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: empty table, extreme keys and values, a repeated key,
		// deletes at the head and tail, and misses.
		directed.push_back(dir_row_t'{krt_pkg::REQ_LIST, 32'h0, 32'h0,
			1'b1, krt_pkg::ST_EMPTY, 32'h0, 32'h0, 6'd0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_SEARCH, 32'h7fff_ffff, 32'h0,
			1'b1, krt_pkg::ST_EMPTY, 32'h0, 32'h0, 6'd0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_DELETE, 32'h8000_0000, 32'hffff_ffff,
			1'b1, krt_pkg::ST_EMPTY, 32'h0, 32'h0, 6'd0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_ADD, 32'h8000_0000, 32'h7fff_ffff,
			1'b1, krt_pkg::ST_OK, 32'h8000_0000, 32'h7fff_ffff, 6'd0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_ADD, 32'h7fff_ffff, 32'h8000_0000,
			1'b1, krt_pkg::ST_OK, 32'h7fff_ffff, 32'h8000_0000, 6'd1});
		directed.push_back(dir_row_t'{krt_pkg::REQ_ADD, 32'h0, 32'h0,
			1'b1, krt_pkg::ST_OK, 32'h0, 32'h0, 6'd2});
		directed.push_back(dir_row_t'{krt_pkg::REQ_ADD, 32'hffff_ffff, 32'hffff_ffff,
			1'b1, krt_pkg::ST_OK, 32'hffff_ffff, 32'hffff_ffff, 6'd3});
		directed.push_back(dir_row_t'{krt_pkg::REQ_ADD, 32'h7fff_ffff, 32'h1,
			1'b1, krt_pkg::ST_OK, 32'h7fff_ffff, 32'h1, 6'd4});
		directed.push_back(dir_row_t'{krt_pkg::REQ_ADD, 32'h5555_5555, 32'haaaa_aaaa,
			1'b1, krt_pkg::ST_OK, 32'h5555_5555, 32'haaaa_aaaa, 6'd5});
		directed.push_back(dir_row_t'{krt_pkg::REQ_LIST, 32'h0, 32'h0,
			1'b0, krt_pkg::ST_OK, '0, '0, '0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_SEARCH, 32'h7fff_ffff, 32'h0,
			1'b0, krt_pkg::ST_OK, '0, '0, '0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_SEARCH, 32'hffff_ffff, 32'h0,
			1'b0, krt_pkg::ST_OK, '0, '0, '0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_SEARCH, 32'h1234_5678, 32'hdead_beef,
			1'b1, krt_pkg::ST_NOTFOUND, 32'h0, 32'h0, 6'd0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_DELETE, 32'h8000_0000, 32'h0,
			1'b0, krt_pkg::ST_OK, '0, '0, '0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_DELETE, 32'h5555_5555, 32'h0,
			1'b0, krt_pkg::ST_OK, '0, '0, '0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_DELETE, 32'h7fff_ffff, 32'h0,
			1'b0, krt_pkg::ST_OK, '0, '0, '0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_SEARCH, 32'h7fff_ffff, 32'h0,
			1'b0, krt_pkg::ST_OK, '0, '0, '0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_DELETE, 32'h0abc_def0, 32'h0,
			1'b1, krt_pkg::ST_NOTFOUND, 32'h0, 32'h0, 6'd0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_ADD, 32'haaaa_aaaa, 32'h5555_5555,
			1'b0, krt_pkg::ST_OK, '0, '0, '0});
		directed.push_back(dir_row_t'{krt_pkg::REQ_LIST, 32'h0, 32'h0,
			1'b0, krt_pkg::ST_OK, '0, '0, '0});
		foreach (directed[i])
			send_request(directed[i].req, directed[i].key, directed[i].value,
				directed[i].typed, krt_pkg::res_t'{directed[i].status, directed[i].exp_key,
					directed[i].exp_value, directed[i].exp_index, 1'b1});
		wait_drained();

		// No idling: fill the table to capacity with a long result hold-off
		// early on, overflow it, list all of it, then shrink it.
		while (tbl_count < TBL_DEPTH) begin
			if (tbl_count == 12)
				hold_request = 1'b1;
			send_request(krt_pkg::REQ_ADD, pick_key(30), $urandom(), 1'b0, '0);
		end
		repeat (3) send_request(krt_pkg::REQ_ADD, pick_key(30), $urandom(), 1'b0, '0);
		send_request(krt_pkg::REQ_LIST, $urandom(), $urandom(), 1'b0, '0);
		repeat (20) send_random(0, 0, 20, 80);
		wait_drained();

		// Idling phases, each walking through growth, mixed use and shrinking.
		for (int p = 0; p < 3; p++) begin
			snd_idle_pct = snd_tab[p];
			rcv_stall_pct = rcv_tab[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				mode = (i / 15 + p) % 3;
				case (mode)
					0: begin
						send_random(60, 5, 15, 20);
					end
					1: begin
						send_random(30, 10, 30, 30);
					end
					default: begin
						send_random(10, 5, 15, 70);
					end
				endcase
			end
			wait_drained();
		end

		// Empty the table by deleting stored keys, then hit it while empty.
		while (tbl_count > 0)
			send_request(krt_pkg::REQ_DELETE, pick_key(100), $urandom(), 1'b0, '0);
		send_request(krt_pkg::REQ_LIST, $urandom(), $urandom(), 1'b0, '0);
		send_request(krt_pkg::REQ_SEARCH, $urandom(), $urandom(), 1'b0, '0);
		send_request(krt_pkg::REQ_DELETE, $urandom(), $urandom(), 1'b0, '0);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d add, %0d list, %0d search, %0d delete).",
			n_requests, n_by_req[krt_pkg::REQ_ADD], n_by_req[krt_pkg::REQ_LIST],
			n_by_req[krt_pkg::REQ_SEARCH], n_by_req[krt_pkg::REQ_DELETE]);
		$display("Checked %0d results; full adds %0d, full lists %0d, empty %0d, misses %0d.",
			n_checked, n_full_adds, n_full_lists, n_on_empty, n_not_found);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
